[rtl/tisa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_pkg
// Shared types and codes of the teaching-ISA execute unit: request and
// result payloads, opcodes and the decoded micro-op handed from front to back.
// ----------------------------------------------------------------------------
package tisa_pkg;

  localparam int NUM_REGS = 32;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int DATA_W   = 32;

  // Request types
  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Opcodes, instruction bits 31..26
  localparam logic [5:0] OP_ADD  = 6'd1;
  localparam logic [5:0] OP_SUB  = 6'd2;
  localparam logic [5:0] OP_ADDI = 6'd17;
  localparam logic [5:0] OP_BNE  = 6'd18;
  localparam logic [5:0] OP_BEQ  = 6'd19;
  localparam logic [5:0] OP_JUMP = 6'd33;
  localparam logic [5:0] OP_LD   = 6'd48;
  localparam logic [5:0] OP_ST   = 6'd49;

  typedef enum logic [3:0] {
    K_ADD,
    K_SUB,
    K_ADDI,
    K_BNE,
    K_BEQ,
    K_JUMP,
    K_STEP,
    K_BAD,
    K_WRITE,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [31:0]              instr_word;
    logic [4:0]               reg_index;
    logic signed [DATA_W-1:0] write_value;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pc_value;
    logic signed [DATA_W-1:0] read_data;
    logic                     unknown_op;
  } rsp_item_t;

  // Decoded operation: dst is the written register, src1/src2 the operand
  // registers, operand_imm the sign-extended immediate or the write value.
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  dst;
    logic [IDX_W-1:0]  src1;
    logic [IDX_W-1:0]  src2;
    logic [DATA_W-1:0] operand_imm;
  } uop_t;

endpackage

[rtl/toy_isa_execute_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_top
// Execute unit for a small teaching ISA: 32 registers of 32 bits with the
// PC as register 0, plus a debug path that writes and reads registers.
// ----------------------------------------------------------------------------
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+------------------------------
//   request  | req_valid, req_ready, req_item   | one execute/write/read request
//   response | rsp_valid, rsp_ready, rsp_item   | PC, read data, unknown flag
//
// One request per cycle sustained while the response side keeps rsp_ready
// high; each transfer in gives exactly one transfer out, in order. A
// result passes through the issue queue, the execute stage (operand read,
// add/compare, register write) and the result register. The queue of
// QUEUE_DEPTH entries absorbs response stalls; req_ready drops only when
// it is full. Reset is synchronous and clears the PC, all register valid
// bits (so every register reads zero) and all pipeline valid state.
//
module toy_isa_execute_unit_top import tisa_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_item
);

  // front to queue
  logic push_valid;
  logic push_ready;
  uop_t push_uop;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  uop_t pop_uop;

  // Decode each request into a micro-op
  tisa_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_item   (req_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop)
  );

  // Hold decoded work while the back end stalls
  tisa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_uop    (pop_uop)
  );

  // Execute against the register file and register the result
  tisa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_uop     (pop_uop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule

[rtl/tisa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_front
// Accepts requests, decodes the instruction word and pushes one micro-op per
// request into the issue queue.
// ----------------------------------------------------------------------------
module tisa_front import tisa_pkg::*; (
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      push_valid,
  input  logic      push_ready,
  output uop_t      push_uop
);

  logic [5:0]        opcode;
  logic [DATA_W-1:0] imm_ext;

  assign opcode  = req_item.instr_word[31:26];
  assign imm_ext = {{(DATA_W - 16){req_item.instr_word[15]}}, req_item.instr_word[15:0]};

  assign req_ready  = push_ready;
  assign push_valid = req_valid;

  always_comb begin
    push_uop.kind        = K_NOP;
    push_uop.dst         = req_item.instr_word[25:21];
    push_uop.src1        = req_item.instr_word[20:16];
    push_uop.src2        = req_item.instr_word[15:11];
    push_uop.operand_imm = imm_ext;
    unique case (req_item.req_type)
      REQ_EXEC: begin
        unique case (opcode)
          OP_ADD:  push_uop.kind = K_ADD;
          OP_SUB:  push_uop.kind = K_SUB;
          OP_ADDI: push_uop.kind = K_ADDI;
          OP_BNE: begin
            // compare r[A] with r[B]
            push_uop.kind = K_BNE;
            push_uop.src1 = req_item.instr_word[25:21];
            push_uop.src2 = req_item.instr_word[20:16];
          end
          OP_BEQ: begin
            push_uop.kind = K_BEQ;
            push_uop.src1 = req_item.instr_word[25:21];
            push_uop.src2 = req_item.instr_word[20:16];
          end
          OP_JUMP: push_uop.kind = K_JUMP;
          OP_LD,
          OP_ST:   push_uop.kind = K_STEP;
          default: push_uop.kind = K_BAD;
        endcase
      end
      REQ_WRITE: begin
        push_uop.kind        = K_WRITE;
        push_uop.dst         = req_item.reg_index;
        push_uop.operand_imm = req_item.write_value;
      end
      REQ_READ: begin
        push_uop.kind = K_READ;
        push_uop.src1 = req_item.reg_index;
      end
      default: push_uop.kind = K_NOP;
    endcase
  end

endmodule

[rtl/tisa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_queue
// Small FIFO of decoded micro-ops between front and back.
// ----------------------------------------------------------------------------
module tisa_queue import tisa_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  uop_t push_uop,
  output logic pop_valid,
  input  logic pop_ready,
  output uop_t pop_uop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uop_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_uop    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tisa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_back
// Register file, execute stage and result register. Operands are read into
// the execute stage with write-through bypass; the PC lives in its own
// register and stands in for register 0.
// ----------------------------------------------------------------------------
module tisa_back import tisa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  uop_t      q_uop,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_item
);

  logic [DATA_W-1:0]   regs [NUM_REGS];
  logic [NUM_REGS-1:0] reg_vld;
  logic [DATA_W-1:0]   pc;
  logic [DATA_W-1:0]   pc_next;

  logic              ex_valid;
  uop_t              ex_uop;
  logic [DATA_W-1:0] ex_opa;
  logic [DATA_W-1:0] ex_opb;
  logic              ex_fire;
  logic              ex_load;

  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] rd_out;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic              wr_go;
  logic              bad;

  assign ex_fire = ex_valid && (!rsp_valid || rsp_ready);
  assign q_ready = !ex_valid || ex_fire;
  assign ex_load = q_valid && q_ready;

  // register 0 is the PC
  assign opa = (ex_uop.src1 == '0) ? pc : ex_opa;
  assign opb = (ex_uop.src2 == '0) ? pc : ex_opb;

  always_comb begin
    pc_next = pc;
    wr_en   = 1'b0;
    wr_data = '0;
    rd_out  = '0;
    bad     = 1'b0;
    alu_res = opa + opb;
    unique case (ex_uop.kind)
      K_ADD:  alu_res = opa + opb;
      K_SUB:  alu_res = opa - opb;
      K_ADDI: alu_res = opa + ex_uop.operand_imm;
      default: alu_res = opa + opb;
    endcase
    unique case (ex_uop.kind)
      K_ADD, K_SUB, K_ADDI: begin
        // destination PC: written, then incremented
        if (ex_uop.dst == '0) begin
          pc_next = alu_res + 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = alu_res;
          pc_next = pc + 1'b1;
        end
      end
      K_BNE:  pc_next = pc + ((opa != opb) ? ex_uop.operand_imm : DATA_W'(1));
      K_BEQ:  pc_next = pc + ((opa == opb) ? ex_uop.operand_imm : DATA_W'(1));
      K_JUMP: pc_next = pc + ex_uop.operand_imm;
      K_STEP: pc_next = pc + 1'b1;
      K_BAD:  bad = 1'b1;
      K_WRITE: begin
        if (ex_uop.dst == '0) begin
          pc_next = ex_uop.operand_imm;
        end else begin
          wr_en   = 1'b1;
          wr_data = ex_uop.operand_imm;
        end
      end
      K_READ:  rd_out = opa;
      default: pc_next = pc;
    endcase
  end

  assign wr_go = ex_fire && wr_en;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      regs[ex_uop.dst] <= wr_data;
    end
  end

  // operand read with bypass of the write retiring in the same cycle
  always_ff @(posedge clk) begin
    if (ex_load) begin
      ex_uop <= q_uop;
      if (wr_go && (ex_uop.dst == q_uop.src1)) begin
        ex_opa <= wr_data;
      end else begin
        ex_opa <= reg_vld[q_uop.src1] ? regs[q_uop.src1] : '0;
      end
      if (wr_go && (ex_uop.dst == q_uop.src2)) begin
        ex_opb <= wr_data;
      end else begin
        ex_opb <= reg_vld[q_uop.src2] ? regs[q_uop.src2] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      rsp_item.pc_value   <= pc_next;
      rsp_item.read_data  <= rd_out;
      rsp_item.unknown_op <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      reg_vld   <= '0;
      pc        <= '0;
    end else begin
      if (q_ready) begin
        ex_valid <= q_valid;
      end
      if (ex_fire) begin
        rsp_valid <= 1'b1;
        pc        <= pc_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (wr_go) begin
        reg_vld[ex_uop.dst] <= 1'b1;
      end
    end
  end

endmodule

[rtl/tisa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module tisa_checker import tisa_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp_item
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 3) + 1;

  logic [CNT_W-1:0]  outstanding;
  logic [DATA_W-1:0] last_pc;
  logic              acc_in;
  logic              acc_out;

  assign acc_in  = req_valid && req_ready;
  assign acc_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_pc     <= '0;
    end else begin
      outstanding <= outstanding + CNT_W'(acc_in) - CNT_W'(acc_out);
      if (acc_out) begin
        last_pc <= rsp_item.pc_value;
      end
    end
  end

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("response changed while stalled");

  // Show no response without a request in flight
  a_rsp_owed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != '0)
    else $error("response without pending request");

  // Bound in-flight requests by queue, execute stage and result register
  a_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(QUEUE_DEPTH + 2))
    else $error("too many requests in flight");

  // Keep the PC on an unknown opcode
  a_bad_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    acc_out && rsp_item.unknown_op |-> rsp_item.pc_value == last_pc)
    else $error("unknown opcode changed the PC");

  // Drop response valid out of reset
  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind toy_isa_execute_unit_top tisa_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tisa_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the teaching-ISA execute unit: a directed sweep of
// operand extremes, every opcode and the PC-as-destination cases, then a long
// random mix of execute, register write, register read and unused-type requests.
// ----------------------------------------------------------------------------
module tb import tisa_pkg::*;;

  // Request type the block must ignore, and two opcodes outside the ISA.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [5:0] OP_NONE    = 6'd0;
  localparam logic [5:0] OP_ALLONES = 6'd63;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  // --------------------------------------------------------------------------
  // Register-file mirror and in-order store of predicted responses.
  // --------------------------------------------------------------------------
  class exec_scoreboard;
    logic [DATA_W-1:0] regs [NUM_REGS];
    rsp_item_t         pending [$];
    int                errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its response.
    function void note_request(req_item_t it);
      rsp_item_t         r;
      logic [5:0]        op;
      logic [4:0]        ra, rb, rc;
      logic [DATA_W-1:0] imm;
      r   = '0;
      op  = it.instr_word[31:26];
      ra  = it.instr_word[25:21];
      rb  = it.instr_word[20:16];
      rc  = it.instr_word[15:11];
      imm = {{16{it.instr_word[15]}}, it.instr_word[15:0]};
      case (it.req_type)
        REQ_EXEC: begin
          case (op)
            OP_ADD: begin
              regs[ra] = regs[rb] + regs[rc];
              regs[0]  = regs[0] + 1;
            end
            OP_SUB: begin
              regs[ra] = regs[rb] - regs[rc];
              regs[0]  = regs[0] + 1;
            end
            OP_ADDI: begin
              regs[ra] = regs[rb] + imm;
              regs[0]  = regs[0] + 1;
            end
            OP_BNE:          regs[0] = regs[0] + ((regs[ra] != regs[rb]) ? imm : 32'd1);
            OP_BEQ:          regs[0] = regs[0] + ((regs[ra] == regs[rb]) ? imm : 32'd1);
            OP_JUMP:         regs[0] = regs[0] + imm;
            OP_LD, OP_ST:    regs[0] = regs[0] + 1;
            default:         r.unknown_op = 1'b1;
          endcase
        end
        REQ_WRITE: regs[it.reg_index] = it.write_value;
        REQ_READ:  r.read_data = regs[it.reg_index];
        default: ;
      endcase
      r.pc_value = regs[0];
      pending = {pending, r};
    endfunction

    // Compare one accepted response against the oldest prediction.
    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (pending.size() == 0) begin
        $error("response with nothing pending: pc_value=%0d read_data=%0d unknown_op=%0b",
               got.pc_value, got.read_data, got.unknown_op);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pc_value !== want.pc_value) begin
        $error("pc_value: expected %0d, actual %0d", want.pc_value, got.pc_value);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0d, actual %0d", want.read_data, got.read_data);
        errors++;
      end
      if (got.unknown_op !== want.unknown_op) begin
        $error("unknown_op: expected %0b, actual %0b", want.unknown_op, got.unknown_op);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req_item;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp_item;

  exec_scoreboard sb;
  bit             steady;   // set: neither side idles
  int             cycles = 0;

  toy_isa_execute_unit_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Item builders. Fields a request type does not use carry random bits so
  // that every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic req_item_t blank_item(input logic [1:0] kind);
    req_item_t it;
    it.req_type    = kind;
    it.instr_word  = $urandom;
    it.reg_index   = 5'($urandom);
    it.write_value = $urandom;
    return it;
  endfunction

  function automatic req_item_t exec_item(input logic [5:0] op, input logic [4:0] a, b, c,
                                          input logic [15:0] imm);
    req_item_t it;
    it            = blank_item(REQ_EXEC);
    it.instr_word = {op, a, b, imm};
    // R-type: field C overlays the top of the immediate
    if (op == OP_ADD || op == OP_SUB) it.instr_word[15:11] = c;
    return it;
  endfunction

  function automatic req_item_t write_item(input logic [4:0] idx, input logic [31:0] val);
    req_item_t it;
    it             = blank_item(REQ_WRITE);
    it.reg_index   = idx;
    it.write_value = val;
    return it;
  endfunction

  function automatic req_item_t read_item(input logic [4:0] idx);
    req_item_t it;
    it           = blank_item(REQ_READ);
    it.reg_index = idx;
    return it;
  endfunction

  // Favor the low registers so operands collide and compare equal often.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(9) < 4) ? 5'($urandom_range(7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(16)) - 32'd8;
      4:          return 32'h7FFF_FFFF;
      5:          return 32'h8000_0000;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_op();
    if ($urandom_range(99) < 8) return 6'($urandom);
    case ($urandom_range(7))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_ADDI;
      3:       return OP_BNE;
      4:       return OP_BEQ;
      5:       return OP_JUMP;
      6:       return OP_LD;
      default: return OP_ST;
    endcase
  endfunction

  function automatic req_item_t random_item();
    int          k;
    logic [5:0]  op;
    logic [4:0]  a, b;
    logic [15:0] imm;
    k   = $urandom_range(99);
    op  = pick_op();
    a   = pick_reg();
    b   = pick_reg();
    imm = ($urandom_range(1) == 0) ? 16'($urandom_range(16)) - 16'd8 : 16'($urandom);
    if (k < 12) return write_item(pick_reg(), pick_value());
    if (k < 24) return read_item(pick_reg());
    if (k < 26) return blank_item(REQ_UNUSED);
    // force equal operands on a share of the branches
    if ((op == OP_BEQ || op == OP_BNE) && $urandom_range(2) == 0) b = a;
    return exec_item(op, a, b, pick_reg(), imm);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: optional idle gap, then hold valid and payload until the
  // transfer. Valid stays high into the next item unless a gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_item_t it);
    while (!steady && $urandom_range(99) < 17) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(it);
  endtask

  // Response side: check each transfer, then draw the next ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_result(rsp_item);
      rsp_ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  // Watchdog: a hang or a prediction left unanswered ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout with %0d responses outstanding", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    sb        = new();
    steady    = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_item  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: register file reads zero after reset.
    send_req(read_item(5'd5));
    // Operand extremes.
    send_req(write_item(5'd1, 32'h7FFF_FFFF));
    send_req(write_item(5'd2, 32'h8000_0000));
    send_req(write_item(5'd3, 32'hFFFF_FFFF));
    send_req(exec_item(OP_ADD, 5'd4, 5'd1, 5'd1, 16'h0));     // wraps
    send_req(exec_item(OP_SUB, 5'd5, 5'd2, 5'd1, 16'h0));     // wraps
    send_req(exec_item(OP_ADDI, 5'd6, 5'd3, 5'd0, 16'h7FFF));
    send_req(exec_item(OP_ADDI, 5'd7, 5'd0, 5'd0, 16'h8000)); // reads PC
    // PC as destination: result lands, then the increment.
    send_req(exec_item(OP_ADD, 5'd0, 5'd1, 5'd3, 16'h0));
    send_req(write_item(5'd0, 32'd100));                       // write PC directly
    send_req(exec_item(OP_SUB, 5'd0, 5'd0, 5'd0, 16'h0));
    send_req(exec_item(OP_ADDI, 5'd0, 5'd31, 5'd0, 16'hFFFF));
    // Branches, taken and not taken, and jumps.
    send_req(exec_item(OP_BEQ, 5'd8, 5'd9, 5'd0, 16'hFFFB));
    send_req(exec_item(OP_BEQ, 5'd1, 5'd2, 5'd0, 16'h0040));
    send_req(exec_item(OP_BNE, 5'd1, 5'd2, 5'd0, 16'h7FFF));
    send_req(exec_item(OP_BNE, 5'd8, 5'd8, 5'd0, 16'h0040));
    send_req(exec_item(OP_JUMP, 5'd0, 5'd0, 5'd0, 16'h8000));
    send_req(exec_item(OP_JUMP, 5'd31, 5'd31, 5'd31, 16'h0));
    send_req(exec_item(OP_LD, 5'd31, 5'd31, 5'd31, 16'hFFFF));
    send_req(exec_item(OP_ST, 5'd0, 5'd0, 5'd0, 16'h0));
    // Unknown opcodes leave state alone; the unused request type changes no state but still gets a response.
    send_req(exec_item(OP_NONE, 5'd1, 5'd2, 5'd3, 16'h1234));
    send_req(exec_item(OP_ALLONES, 5'd31, 5'd31, 5'd31, 16'hFFFF));
    send_req(blank_item(REQ_UNUSED));
    send_req(exec_item(OP_ADDI, 5'd31, 5'd31, 5'd0, 16'h7FFF));
    send_req(read_item(5'd31));
    send_req(read_item(5'd0));

    // Random mix, with a stretch of back-to-back transfers on both sides.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 600 && n < 900);
      send_req(random_item());
    end
    req_valid <= 1'b0;

    // Drain, then allow for stray responses.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
